FILE: hw/rtl/gamepad_touch_event_mapper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad touch event mapper
// Concurrent checks clocked on the rising edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_TOUCH_EVENT_MAPPER_MACROS_SVH
`define GAMEPAD_TOUCH_EVENT_MAPPER_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every edge out of reset
`define GTEM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("gtem check failed");

// consequent must hold in the cycle after the antecedent
`define GTEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("gtem check failed");

`else

`define GTEM_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define GTEM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/gtem_pkg.sv
// ----------------------------------------------------------------------------
// gtem_pkg
// Types, codes and helpers shared by the gamepad touch event mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package gtem_pkg;

	localparam int NSLOTS = 15;

	// event kinds
	localparam logic [1:0] KIND_DOWN = 2'd0;
	localparam logic [1:0] KIND_UP   = 2'd1;
	localparam logic [1:0] KIND_MOVE = 2'd2;
	localparam logic [1:0] KIND_QUIT = 2'd3;

	// key codes beyond the eight button keys
	localparam logic [3:0] KEY_WHEEL_UP   = 4'd8;
	localparam logic [3:0] KEY_WHEEL_DOWN = 4'd9;
	localparam logic [3:0] KEY_MOUSE1     = 4'd10;

	// configuration register indexes
	localparam logic [1:0] CFG_REPEAT_DELAY = 2'd0;
	localparam logic [1:0] CFG_REPEAT_RATE  = 2'd1;
	localparam logic [1:0] CFG_DEADZONE     = 2'd2;
	localparam logic [1:0] CFG_STICK_PERIOD = 2'd3;

	localparam logic [15:0] RESET_DELAY_MS   = 16'd400;
	localparam logic [15:0] RESET_RATE_MS    = 16'd60;
	localparam logic [6:0]  RESET_DEADZONE   = 7'd40;
	localparam logic [15:0] RESET_STICK_MS   = 16'd50;

	localparam int BTN_SELECT = 8;
	localparam int BTN_START  = 9;
	localparam logic [7:0] REPEAT_SET = 8'hCF;
	localparam logic [8:0] STICK_CENTER = 9'd128;

	localparam logic [25:0] US_PER_MS = 26'd1000;
	localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;

	// event list slots, in emit order
	localparam int SLOT_QUIT      = 0;
	localparam int SLOT_BTN0      = 0;
	localparam int SLOT_REP_DOWN  = 8;
	localparam int SLOT_REP_UP    = 9;
	localparam int SLOT_STK_MOVE  = 10;
	localparam int SLOT_STK_DOWN  = 11;
	localparam int SLOT_STK_UP    = 12;
	localparam int SLOT_TCH_MOVE  = 13;
	localparam int SLOT_TCH_KEY   = 14;

	typedef struct packed {
		logic [47:0] now_us;
		logic [9:0]  button_levels;
		logic [7:0]  stick_y;
		logic        touch_present;
		logic [10:0] touch_raw_x;
		logic [10:0] touch_raw_y;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [3:0] key_code;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic       last_event;
	} out_item_t;

	typedef out_item_t [NSLOTS-1:0] slot_list_t;
	typedef logic [NSLOTS-1:0] slot_mask_t;

	typedef struct packed {
		logic [25:0] wait_us;
		logic [25:0] rate_us;
		logic [6:0]  deadzone;
		logic [25:0] stick_us;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  prev_buttons;
		logic [7:0]  repeat_btn;
		logic [47:0] repeat_due;
		logic [47:0] stick_due;
		logic        touch_on;
		logic [9:0]  last_tx;
		logic [9:0]  last_ty;
		logic [9:0]  cursor_x;
		logic [9:0]  cursor_y;
	} state_t;

	function automatic logic [25:0] ms_to_us(input logic [15:0] ms);
		return 26'(ms) * US_PER_MS;
	endfunction

	// now plus an interval, saturating at the top of the time range
	function automatic logic [47:0] due_after(input logic [47:0] now, input logic [25:0] us);
		logic [48:0] sum;
		sum = {1'b0, now} + 49'(us);
		return sum[48] ? TIME_MAX : sum[47:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gamepad_touch_event_mapper.sv
// ----------------------------------------------------------------------------
// gamepad_touch_event_mapper
// Turns gamepad and touch poll samples into key, pointer and quit events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one poll sample per transfer (valid/stall, receiver stalls).
//   out_*  : one event per transfer; last_event marks the final event of a
//            poll. A poll that causes no event produces no transfer.
//   cfg_*  : register writes (valid/ready, ready is always high); write only
//            while idle. Intervals are given in ms and kept internally in us.
// Flow:
//   A sample passes through the input stage and the event list register
//   before its first event reaches the output register. A poll gives at
//   most fifteen events. The next sample is taken while those events drain,
//   and its events follow the previous poll's last event with no gap while
//   the output does not stall, so the single output sets the pace.
// Reset:
//   Clears all event and pipeline state, loads the default intervals and
//   dead zone, and centers the cursor. No clearing pass is needed.
// Stall:
//   A stalled event holds in the output register; the event list and the
//   input stage then fill and in_stall rises until the output moves again.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gamepad_touch_event_mapper_macros.svh"

module gamepad_touch_event_mapper #(
	parameter int SCREEN_W = 960,
	parameter int SCREEN_H = 544
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gtem_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gtem_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import gtem_pkg::*;

	localparam logic [9:0] CURSOR_X_RESET = 10'(SCREEN_W / 2);
	localparam logic [9:0] CURSOR_Y_RESET = 10'(SCREEN_H / 2);

	cfg_t         cfg_q;
	state_t       state_q;
	state_t       state_nxt;
	logic         valid_s1;
	in_item_t     item_s1;
	slot_list_t   gen_slots;
	slot_mask_t   gen_mask;
	logic         buf_free;
	logic         advance;
	logic         in_accept;
	logic         cursor_ok;
	logic         quit_adv;
	logic [103:0] timing_q;

	// the sample in stage one retires into the event list once it is free
	assign advance   = valid_s1 && buf_free;
	assign in_stall  = valid_s1 && !buf_free;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration: store intervals as microseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_us  <= ms_to_us(RESET_DELAY_MS);
			cfg_q.rate_us  <= ms_to_us(RESET_RATE_MS);
			cfg_q.deadzone <= RESET_DEADZONE;
			cfg_q.stick_us <= ms_to_us(RESET_STICK_MS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REPEAT_DELAY: cfg_q.wait_us  <= ms_to_us(cfg_data);
				CFG_REPEAT_RATE:  cfg_q.rate_us  <= ms_to_us(cfg_data);
				CFG_DEADZONE:     cfg_q.deadzone <= cfg_data[6:0];
				CFG_STICK_PERIOD: cfg_q.stick_us <= ms_to_us(cfg_data);
				default: ;
			endcase
		end
	end

	// input stage: take a sample, hold it until it retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	gtem_event_gen #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_event_gen (
		.item  (item_s1),
		.state (state_q),
		.cfg   (cfg_q),
		.slots (gen_slots),
		.mask  (gen_mask),
		.nxt   (state_nxt)
	);

	// advance the poll state exactly when the sample's events are captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prev_buttons <= '0;
			state_q.repeat_btn   <= '0;
			state_q.repeat_due   <= '0;
			state_q.stick_due    <= '0;
			state_q.touch_on     <= 1'b0;
			state_q.last_tx      <= '0;
			state_q.last_ty      <= '0;
			state_q.cursor_x     <= CURSOR_X_RESET;
			state_q.cursor_y     <= CURSOR_Y_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	gtem_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.slots_in  (gen_slots),
		.mask_in   (gen_mask),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign cursor_ok = ({1'b0, state_q.cursor_x} < 11'(SCREEN_W)) &&
		({1'b0, state_q.cursor_y} < 11'(SCREEN_H));
	assign quit_adv  = advance && item_s1.button_levels[BTN_SELECT] &&
		item_s1.button_levels[BTN_START];
	assign timing_q  = {state_q.repeat_btn, state_q.repeat_due, state_q.stick_due};

	// repeat is owned by at most one button
	`GTEM_ASSERT_ALWAYS(a_repeat_onehot, clk, arst_n, $onehot0(state_q.repeat_btn))
	// the cursor never leaves the screen
	`GTEM_ASSERT_ALWAYS(a_cursor_range, clk, arst_n, cursor_ok)
	// a quit poll leaves repeat and stick timing alone
	`GTEM_ASSERT_NEXT(a_quit_keeps_timing, clk, arst_n, quit_adv, $stable(timing_q))

endmodule

`default_nettype wire

FILE: hw/rtl/gtem_event_gen.sv
// ----------------------------------------------------------------------------
// gtem_event_gen
// Builds the slotted event list and next state for one poll sample.
// ----------------------------------------------------------------------------
`default_nettype none

module gtem_event_gen #(
	parameter int SCREEN_W = 960,
	parameter int SCREEN_H = 544
) (
	input  gtem_pkg::in_item_t   item,
	input  gtem_pkg::state_t     state,
	input  gtem_pkg::cfg_t       cfg,
	output gtem_pkg::slot_list_t slots,
	output gtem_pkg::slot_mask_t mask,
	output gtem_pkg::state_t     nxt
);
	import gtem_pkg::*;

	localparam logic [10:0] W_LIM = 11'(SCREEN_W);
	localparam logic [10:0] H_LIM = 11'(SCREEN_H);
	localparam logic [9:0]  W_MAX = 10'(SCREEN_W - 1);
	localparam logic [9:0]  H_MAX = 10'(SCREEN_H - 1);

	logic [47:0] now;
	logic [9:0]  levels;
	logic [9:0]  pressed;
	logic [9:0]  released;
	logic        quit;
	logic [7:0]  rb;
	logic        rep_press;
	logic [2:0]  rb_idx;
	logic        rep_due;
	logic        rep_fire;
	logic        stick_out;
	logic [8:0]  y9;
	logic [8:0]  dz9;
	logic [9:0]  tx;
	logic [9:0]  ty;
	logic [9:0]  cx;
	logic [9:0]  cy;
	logic [3:0]  wheel_key;

	assign now      = item.now_us;
	assign levels   = item.button_levels;
	assign pressed  = levels & ~state.prev_buttons;
	assign released = state.prev_buttons & ~levels;
	assign quit     = levels[BTN_SELECT] & levels[BTN_START];

	assign y9  = {1'b0, item.stick_y};
	assign dz9 = {2'b00, cfg.deadzone};
	assign stick_out = ((y9 + dz9) < STICK_CENTER) || (y9 > (STICK_CENTER + dz9));
	assign wheel_key = item.stick_y[7] ? KEY_WHEEL_DOWN : KEY_WHEEL_UP;

	// halve the raw touch position, clamp for the move
	assign tx = item.touch_raw_x[10:1];
	assign ty = item.touch_raw_y[10:1];
	assign cx = ({1'b0, tx} >= W_LIM) ? W_MAX : tx;
	assign cy = ({1'b0, ty} >= H_LIM) ? H_MAX : ty;

	always_comb begin
		slots     = '0;
		mask      = '0;
		nxt       = state;
		rb        = state.repeat_btn;
		rep_press = 1'b0;
		rb_idx    = '0;
		rep_due   = 1'b0;
		rep_fire  = 1'b0;
		nxt.prev_buttons = levels;

		if (quit) begin
			slots[SLOT_QUIT].event_kind = KIND_QUIT;
			mask[SLOT_QUIT] = 1'b1;
		end else begin
			for (int i = 0; i < 8; i++) begin
				if (pressed[i]) begin
					slots[SLOT_BTN0 + i].event_kind = KIND_DOWN;
					slots[SLOT_BTN0 + i].key_code   = 4'(i);
					mask[SLOT_BTN0 + i] = 1'b1;
					if (REPEAT_SET[i]) begin
						rb        = 8'(1) << i;
						rep_press = 1'b1;
					end
				end
				if (released[i]) begin
					slots[SLOT_BTN0 + i].event_kind = KIND_UP;
					slots[SLOT_BTN0 + i].key_code   = 4'(i);
					mask[SLOT_BTN0 + i] = 1'b1;
					if (rb == (8'(1) << i)) begin
						rb = '0;
					end
				end
			end
			for (int i = 0; i < 8; i++) begin
				if (rb[i]) begin
					rb_idx = rb_idx | 3'(i);
				end
			end
			// a fresh due time of now+delay is already reached only when the
			// delay is zero or the sum saturates at now itself
			if (rep_press) begin
				rep_due = (cfg.wait_us == '0) || (now == TIME_MAX);
			end else begin
				rep_due = now >= state.repeat_due;
			end
			rep_fire = (rb != '0) && ((levels[7:0] & rb) != '0) && rep_due;

			nxt.repeat_btn = rb;
			if (rep_fire) begin
				slots[SLOT_REP_DOWN].event_kind = KIND_DOWN;
				slots[SLOT_REP_DOWN].key_code   = {1'b0, rb_idx};
				slots[SLOT_REP_UP].event_kind   = KIND_UP;
				slots[SLOT_REP_UP].key_code     = {1'b0, rb_idx};
				mask[SLOT_REP_DOWN] = 1'b1;
				mask[SLOT_REP_UP]   = 1'b1;
				nxt.repeat_due = due_after(now, cfg.rate_us);
			end else if (rep_press) begin
				nxt.repeat_due = due_after(now, cfg.wait_us);
			end

			if ((now >= state.stick_due) && stick_out) begin
				slots[SLOT_STK_MOVE].event_kind = KIND_MOVE;
				slots[SLOT_STK_MOVE].pos_x      = state.cursor_x;
				slots[SLOT_STK_MOVE].pos_y      = state.cursor_y;
				slots[SLOT_STK_DOWN].event_kind = KIND_DOWN;
				slots[SLOT_STK_DOWN].key_code   = wheel_key;
				slots[SLOT_STK_UP].event_kind   = KIND_UP;
				slots[SLOT_STK_UP].key_code     = wheel_key;
				mask[SLOT_STK_MOVE] = 1'b1;
				mask[SLOT_STK_DOWN] = 1'b1;
				mask[SLOT_STK_UP]   = 1'b1;
				nxt.stick_due = due_after(now, cfg.stick_us);
			end
		end

		if (item.touch_present) begin
			if (!state.touch_on || (tx != state.last_tx) || (ty != state.last_ty)) begin
				nxt.last_tx  = tx;
				nxt.last_ty  = ty;
				nxt.cursor_x = cx;
				nxt.cursor_y = cy;
				slots[SLOT_TCH_MOVE].event_kind = KIND_MOVE;
				slots[SLOT_TCH_MOVE].pos_x      = cx;
				slots[SLOT_TCH_MOVE].pos_y      = cy;
				mask[SLOT_TCH_MOVE] = 1'b1;
			end
			if (!state.touch_on) begin
				nxt.touch_on = 1'b1;
				slots[SLOT_TCH_KEY].event_kind = KIND_DOWN;
				slots[SLOT_TCH_KEY].key_code   = KEY_MOUSE1;
				mask[SLOT_TCH_KEY] = 1'b1;
			end
		end else if (state.touch_on) begin
			nxt.touch_on = 1'b0;
			slots[SLOT_TCH_KEY].event_kind = KIND_UP;
			slots[SLOT_TCH_KEY].key_code   = KEY_MOUSE1;
			mask[SLOT_TCH_KEY] = 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/gtem_drain.sv
// ----------------------------------------------------------------------------
// gtem_drain
// Holds one poll's event list and sends the events out one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gtem_drain (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  gtem_pkg::slot_list_t slots_in,
	input  gtem_pkg::slot_mask_t mask_in,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_stall,
	output gtem_pkg::out_item_t  out_data
);
	import gtem_pkg::*;

	slot_list_t slots_q;
	slot_mask_t mask_q;
	slot_mask_t lowest;
	slot_mask_t mask_rest;
	logic       pop;
	out_item_t  pick;
	logic       out_valid_q;
	out_item_t  out_data_q;

	assign pop       = (mask_q != '0) && (!out_valid_q || !out_stall);
	assign lowest    = mask_q & (~mask_q + 1'b1);
	assign mask_rest = mask_q & ~lowest;
	assign free      = pop ? (mask_rest == '0) : (mask_q == '0);

	always_comb begin
		pick = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			if (lowest[i]) begin
				pick = pick | slots_q[i];
			end
		end
		pick.last_event = (mask_rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= mask_in;
		end else if (pop) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= slots_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= pick;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
